### rtl/core/rsh_pkg.sv
package rsh_pkg;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [0:0] REG_BYTES_SIGNED = 1'b0;

	localparam logic BYTES_SIGNED_RESET = 1'b1;

	// position term in units of 0x100, low byte is always zero
	localparam int POS_W = 56;
	localparam logic [POS_W-1:0] POS_START = 56'd1;

	typedef struct packed {
		logic [63:0] square;
		logic [3:0]  rot;
		logic        last;
		logic        empty;
	} rsh_op_t;

endpackage

### rtl/core/rsh_queue.sv
module rsh_queue import rsh_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  rsh_op_t push_op,
	output logic    full,
	input  logic    pop,
	output rsh_op_t head_op,
	output logic    head_valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	rsh_op_t          slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_op    = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/rsh_front.sv
module rsh_front import rsh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       bytes_signed,
	input  logic       key_valid,
	output logic       key_stall,
	input  logic [7:0] key_byte,
	input  logic       last_byte,
	input  logic       empty_key,
	output logic       push,
	output rsh_op_t    push_op,
	input  logic       queue_full
);

	logic [POS_W-1:0] pos_q;
	logic             accept;
	logic [63:0]      v;
	logic [31:0]      v_hi;
	logic [31:0]      v_lo;
	logic [63:0]      prod_ll;
	logic [31:0]      prod_hl;

	logic             valid_s1;
	logic [63:0]      p_ll_s1;
	logic [31:0]      p_hl_s1;
	logic [3:0]       rot_s1;
	logic             last_s1;
	logic             empty_s1;

	assign key_stall = valid_s1 && queue_full;
	assign accept    = key_valid && !key_stall;

	// sign extension fills every bit above the byte, which swamps the position term
	assign v = (bytes_signed && key_byte[7]) ? {{POS_W{1'b1}}, key_byte} : {pos_q, key_byte};
	assign v_hi = v[63:32];
	assign v_lo = v[31:0];

	// v*v mod 2^64 = lo*lo + ((2*hi*lo) mod 2^32) << 32
	assign prod_ll = v_lo * v_lo;
	assign prod_hl = v_hi * v_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_START;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				pos_q <= (empty_key || last_byte) ? POS_START : pos_q + 1'b1;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (!queue_full) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_ll_s1  <= prod_ll;
			p_hl_s1  <= prod_hl;
			rot_s1   <= v[5:2] ^ v[3:0];
			last_s1  <= last_byte;
			empty_s1 <= empty_key;
		end
	end

	assign push           = valid_s1 && !queue_full;
	assign push_op.square = p_ll_s1 + {p_hl_s1[30:0], 1'b0, 32'd0};
	assign push_op.rot    = rot_s1;
	assign push_op.last   = last_s1;
	assign push_op.empty  = empty_s1;

endmodule

### rtl/core/rsh_back.sv
module rsh_back import rsh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rsh_op_t     head_op,
	input  logic        head_valid,
	output logic        pop,
	output logic        hash_valid,
	input  logic        hash_stall,
	output logic [63:0] hash_value
);

	logic [63:0] acc_q;
	logic        out_valid_q;
	logic [63:0] out_value_q;
	logic        needs_out;
	logic        out_free;
	logic [63:0] shl;
	logic [63:0] shr;
	logic [31:0] rot_low;
	logic [63:0] acc_next;
	logic [63:0] hash_next;

	// the right shift runs on all 64 bits, so upper accumulator bits leak low
	assign shl      = acc_q << head_op.rot;
	assign shr      = acc_q >> (6'd32 - {2'b00, head_op.rot});
	assign rot_low  = shl[31:0] | shr[31:0];
	assign acc_next = {head_op.square[63:32], rot_low ^ head_op.square[31:0]};
	assign hash_next = head_op.empty ? 64'd0 : ((acc_next >> 16) ^ acc_next);

	assign needs_out = head_op.last || head_op.empty;
	assign out_free  = !out_valid_q || !hash_stall;
	assign pop       = head_valid && (!needs_out || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q <= needs_out ? 64'd0 : acc_next;
			end
			if (pop && needs_out) begin
				out_valid_q <= 1'b1;
			end else if (!hash_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && needs_out) begin
			out_value_q <= hash_next;
		end
	end

	assign hash_valid = out_valid_q;
	assign hash_value = out_value_q;

endmodule

### rtl/core/rotating_square_string_hash_core.sv
// Rotating-square string hash, one key byte per word.
// Input channel (key_valid / key_stall): one key byte per word with last_byte
// marking the final byte; empty_key marks a zero-length key, whose byte and
// last flag are ignored and which yields a hash of 0.
// Output channel (hash_valid / hash_stall): one 64-bit hash_value word per key.
// Throughput: one byte word per cycle sustained while hash_stall is low. The
// front stage forms the square of each byte term ahead of time (two 32x32
// multipliers and one add), so the back end only rotates and XORs the
// accumulator each cycle. A final byte's hash word passes the front stage
// register, a queue slot and the output register. A stalled output holds its
// word; the front-to-back queue fills with byte words, then key_stall rises.
// Reset: accumulator clears, position term returns to 0x100, bytes_signed = 1,
// queue and output empty. bytes_signed lives at APB byte address 0 and should
// be written only while no key is in flight.
module rotating_square_string_hash_core import rsh_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               key_valid,
	output logic               key_stall,
	input  logic [7:0]         key_byte,
	input  logic               last_byte,
	input  logic               empty_key,
	output logic               hash_valid,
	input  logic               hash_stall,
	output logic [63:0]        hash_value
);

	logic    bytes_signed_q;
	logic    cfg_write;
	logic    push;
	logic    pop;
	logic    queue_full;
	logic    head_valid;
	rsh_op_t push_op;
	rsh_op_t head_op;

	// Register file: a single bit at word index 0, other addresses read zero
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_signed_q <= BYTES_SIGNED_RESET;
		end else if (cfg_write && (paddr[2:2] == REG_BYTES_SIGNED)) begin
			bytes_signed_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2:2] == REG_BYTES_SIGNED) begin
			prdata[0] = bytes_signed_q;
		end
	end

	// Front: extend byte, track position, precompute v*v and rotate amount
	rsh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.bytes_signed (bytes_signed_q),
		.key_valid    (key_valid),
		.key_stall    (key_stall),
		.key_byte     (key_byte),
		.last_byte    (last_byte),
		.empty_key    (empty_key),
		.push         (push),
		.push_op      (push_op),
		.queue_full   (queue_full)
	);

	// Short queue so front and back can stall independently
	rsh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (queue_full),
		.pop        (pop),
		.head_op    (head_op),
		.head_valid (head_valid)
	);

	// Back: accumulator recurrence and registered result word
	rsh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_op    (head_op),
		.head_valid (head_valid),
		.pop        (pop),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall),
		.hash_value (hash_value)
	);

endmodule
